@@ sv/fbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the frustum box cull block
// Transaction payloads, the stage record that travels along the cell chain,
// register indexes and fixed-point widths.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int COORD_BITS = 16;   // signed Q10.6 coordinates
  localparam int NORM_BITS  = 16;   // signed Q1.14 normals; also the width of the offset field
  localparam int MASK_W     = 5;
  localparam int REG_PLANES = 5;    // plane registers occupy indexes 0..4
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 64;
  localparam int FRUSTUM_W  = 3 * COORD_BITS;
  localparam int PROD_W     = COORD_BITS + NORM_BITS;
  localparam int DIST_W     = PROD_W + 4;
  localparam int OFF_SHIFT  = 14;   // offset Q10.6 scaled to the Q.20 product grid

  localparam logic [IDX_W-1:0] REG_FRUSTUM_MIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_FRUSTUM_MAX = 3'd6;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [NORM_BITS-1:0]  norm_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DIST_W-1:0]     dist_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask_in;
    coord_t            box_min_x;
    coord_t            box_min_y;
    coord_t            box_min_z;
    coord_t            box_max_x;
    coord_t            box_max_y;
    coord_t            box_max_z;
  } box_item_t;

  typedef struct packed {
    logic              visible;
    logic [MASK_W-1:0] mask_out;
  } result_t;

  // One box in flight between cells.
  typedef struct packed {
    logic              valid;
    logic              zero_mask;  // mask was empty on entry: visible at once
    logic              alive;      // no plane has culled the box yet
    logic [MASK_W-1:0] mask;       // working mask, inside planes cleared
    box_item_t         box;
  } stage_t;

endpackage

@@ sv/fbc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_cell: one plane test cell of the chain
// Holds one plane and tests the passing box against it in two stages:
// corner select and multiply, then sum, compare and mask update.
// ----------------------------------------------------------------------------
module fbc_cell #(
  parameter int PLANE_INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [fbc_pkg::IDX_W-1:0]     wr_index,
  input  logic [fbc_pkg::DATA_W-1:0]    wr_data,
  input  fbc_pkg::stage_t               in_stage,
  output fbc_pkg::stage_t               out_stage
);

  localparam logic [fbc_pkg::IDX_W-1:0] MY_INDEX = PLANE_INDEX[fbc_pkg::IDX_W-1:0];

  fbc_pkg::norm_t nx, ny, nz, off;

  always_ff @(posedge clk) begin
    if (rst) begin
      nx  <= '0;
      ny  <= '0;
      nz  <= '0;
      off <= '0;
    end else if (wr_en && wr_index == MY_INDEX) begin
      nx  <= wr_data[15:0];
      ny  <= wr_data[31:16];
      nz  <= wr_data[47:32];
      off <= wr_data[63:48];
    end
  end

  // The near corner takes the maximum on an axis whose normal is negative.
  fbc_pkg::coord_t near_x, near_y, near_z, far_x, far_y, far_z;

  always_comb begin
    near_x = nx[15] ? in_stage.box.box_max_x : in_stage.box.box_min_x;
    near_y = ny[15] ? in_stage.box.box_max_y : in_stage.box.box_min_y;
    near_z = nz[15] ? in_stage.box.box_max_z : in_stage.box.box_min_z;
    far_x  = nx[15] ? in_stage.box.box_min_x : in_stage.box.box_max_x;
    far_y  = ny[15] ? in_stage.box.box_min_y : in_stage.box.box_max_y;
    far_z  = nz[15] ? in_stage.box.box_min_z : in_stage.box.box_max_z;
  end

  fbc_pkg::stage_t a_stage;
  fbc_pkg::prod_t  pn_x, pn_y, pn_z, pf_x, pf_y, pf_z;

  always_ff @(posedge clk) begin
    pn_x    <= fbc_pkg::prod_t'(nx) * fbc_pkg::prod_t'(near_x);
    pn_y    <= fbc_pkg::prod_t'(ny) * fbc_pkg::prod_t'(near_y);
    pn_z    <= fbc_pkg::prod_t'(nz) * fbc_pkg::prod_t'(near_z);
    pf_x    <= fbc_pkg::prod_t'(nx) * fbc_pkg::prod_t'(far_x);
    pf_y    <= fbc_pkg::prod_t'(ny) * fbc_pkg::prod_t'(far_y);
    pf_z    <= fbc_pkg::prod_t'(nz) * fbc_pkg::prod_t'(far_z);
    if (rst) begin
      a_stage <= '0;
    end else begin
      a_stage <= in_stage;
    end
  end

  fbc_pkg::dist_t  off_term, near_d, far_d;
  fbc_pkg::stage_t out_stage_next;

  always_comb begin
    off_term = fbc_pkg::dist_t'(off) <<< fbc_pkg::OFF_SHIFT;
    near_d   = fbc_pkg::dist_t'(pn_x) + fbc_pkg::dist_t'(pn_y)
             + fbc_pkg::dist_t'(pn_z) - off_term;
    far_d    = fbc_pkg::dist_t'(pf_x) + fbc_pkg::dist_t'(pf_y)
             + fbc_pkg::dist_t'(pf_z) - off_term;
    out_stage_next = a_stage;
    if (a_stage.alive && a_stage.mask[PLANE_INDEX]) begin
      if (!near_d[fbc_pkg::DIST_W-1]) begin
        out_stage_next.alive = 1'b0;
      end else if (far_d[fbc_pkg::DIST_W-1] || far_d == '0) begin
        out_stage_next.mask[PLANE_INDEX] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage <= '0;
    end else begin
      out_stage <= out_stage_next;
    end
  end

endmodule

@@ sv/fbc_bound.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_bound: frustum bounding box test and result register
// Holds the frustum corner registers, tests a surviving box for inclusive
// overlap and registers the final result with its strobe.
// ----------------------------------------------------------------------------
module fbc_bound (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [fbc_pkg::IDX_W-1:0]     wr_index,
  input  logic [fbc_pkg::DATA_W-1:0]    wr_data,
  input  fbc_pkg::stage_t               in_stage,
  output logic                          done,
  output fbc_pkg::result_t              result
);

  logic [fbc_pkg::FRUSTUM_W-1:0] fmin, fmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmin <= '0;
      fmax <= '0;
    end else if (wr_en) begin
      if (wr_index == fbc_pkg::REG_FRUSTUM_MIN) begin
        fmin <= wr_data[fbc_pkg::FRUSTUM_W-1:0];
      end
      if (wr_index == fbc_pkg::REG_FRUSTUM_MAX) begin
        fmax <= wr_data[fbc_pkg::FRUSTUM_W-1:0];
      end
    end
  end

  fbc_pkg::coord_t  fmin_x, fmin_y, fmin_z, fmax_x, fmax_y, fmax_z;
  logic             outside, keep;
  fbc_pkg::result_t result_next;

  always_comb begin
    fmin_x  = fmin[15:0];
    fmin_y  = fmin[31:16];
    fmin_z  = fmin[47:32];
    fmax_x  = fmax[15:0];
    fmax_y  = fmax[31:16];
    fmax_z  = fmax[47:32];
    outside = (in_stage.box.box_min_x > fmax_x) || (in_stage.box.box_max_x < fmin_x)
           || (in_stage.box.box_min_y > fmax_y) || (in_stage.box.box_max_y < fmin_y)
           || (in_stage.box.box_min_z > fmax_z) || (in_stage.box.box_max_z < fmin_z);
    keep    = in_stage.alive && !outside;
    if (in_stage.zero_mask) begin
      result_next.visible  = 1'b1;
      result_next.mask_out = '0;
    end else begin
      result_next.visible  = keep;
      result_next.mask_out = keep ? in_stage.mask : '0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_stage.valid;
    end
  end

endmodule

@@ sv/frustum_box_cull.sv @@
`timescale 1ns / 1ps
// Throughput: one box per cycle; every plane cell is a two-stage pipeline.
// The receiver cannot stall: each result shows on result for one cycle with done.
// Reset clears the pipeline valid bits and all configuration registers to 0;
// busy is high only while reset is held.
// ----------------------------------------------------------------------------
// frustum_box_cull: axis-aligned box visibility test against view planes
// A chain of plane cells followed by a bounding box stage.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
  parameter int NUM_PLANES = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fbc_pkg::box_item_t            box,
  output logic                          done,
  output fbc_pkg::result_t              result,
  input  logic                          wr_en,
  input  logic [fbc_pkg::IDX_W-1:0]     wr_index,
  input  logic [fbc_pkg::DATA_W-1:0]    wr_data
);

  // Only five plane registers exist, and the mask is five bits wide, so a
  // plane beyond the fifth could never be written nor tested.
  localparam int NP  = (NUM_PLANES < fbc_pkg::REG_PLANES) ? NUM_PLANES
                                                          : fbc_pkg::REG_PLANES;
  localparam int LAT = 2 * NP + 1;

  // The pipeline never stalls, so a transaction is refused only during reset.
  assign busy = rst;

  fbc_pkg::stage_t chain [0:NP];

  // Entry record: a box with an empty mask is marked visible and skips
  // every test; the cells pass it along untouched.
  always_comb begin
    chain[0].valid     = start && !busy;
    chain[0].zero_mask = (box.mask_in == '0);
    chain[0].alive     = 1'b1;
    chain[0].mask      = box.mask_in;
    chain[0].box       = box;
  end

  // Each cell owns one plane. Cell i tests only when mask bit i is set and no
  // earlier cell has culled the box; a culled box rides on with alive low.
  for (genvar i = 0; i < NP; i++) begin : g_cell
    fbc_cell #(
      .PLANE_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_index  (wr_index),
      .wr_data   (wr_data),
      .in_stage  (chain[i]),
      .out_stage (chain[i+1])
    );
  end

  // Survivors of the plane tests are checked against the frustum bounds, and
  // the result register drives the output ports.
  fbc_bound u_bound (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_stage (chain[NP]),
    .done     (done),
    .result   (result)
  );

  // Every accepted transaction yields exactly one result.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LAT))
    else $error("result strobe does not follow an accepted transaction");

  // A culled box reports an empty mask.
  a_culled_mask: assert property (@(posedge clk) disable iff (rst)
    done && !result.visible |-> result.mask_out == '0)
    else $error("culled box carries a mask");

  // Planes are only ever cleared from the mask, never added.
  a_mask_subset: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.mask_out & ~$past(box.mask_in, LAT)) == '0)
    else $error("result mask holds a plane not in the input mask");

endmodule
